/* src/yaz0_pkg.sv */
`default_nettype none

package yaz0_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int LANES      = 8;
    localparam int PACK_W     = LANES * 8;
    localparam int CNT_W      = $clog2(LANES + 1);

    localparam int HDR_LEN        = 16;
    localparam int SIZE_FIRST     = 4;
    localparam int SIZE_END       = 8;
    localparam int MAGIC_LEN      = 4;
    localparam logic [8:0] SHORT_LEN_BASE = 9'd2;
    localparam logic [8:0] LONG_LEN_BASE  = 9'h12;

    localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h59, 8'h61, 8'h7A, 8'h30};

    typedef logic [7:0]         byte_t;
    typedef logic [HIST_AW-1:0] hist_addr_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_MAGIC   = 3'd1,
        ERR_TRUNC   = 3'd2,
        ERR_DIST    = 3'd3,
        ERR_OVERRUN = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_LIT,
        PH_REF1,
        PH_REF2,
        PH_REF3,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_PRIME,
        SQ_COPY,
        SQ_FINAL
    } seq_t;

    typedef struct packed {
        logic [7:0] flag;
        logic [3:0] bits_left;
        phase_t     phase;
    } item_state_t;

endpackage

`default_nettype wire

/* src/yaz0_in_if.sv */
`default_nettype none

interface yaz0_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

/* src/yaz0_out_if.sv */
`default_nettype none

interface yaz0_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        end_of_run;
    logic        done_res;
    logic [2:0]  error_code;

    modport source (output valid, output out_bytes, output out_count, output end_of_run,
                    output done_res, output error_code, input ready);
    modport sink   (input valid, input out_bytes, input out_count, input end_of_run,
                    input done_res, input error_code, output ready);
endinterface

`default_nettype wire

/* src/yaz0_hist_ram.sv */
`default_nettype none

module yaz0_hist_ram (
    input  wire                  clk,
    input  wire                  we,
    input  wire yaz0_pkg::hist_addr_t waddr,
    input  wire yaz0_pkg::byte_t wdata,
    input  wire yaz0_pkg::hist_addr_t raddr,
    output yaz0_pkg::byte_t      rdata
);
    import yaz0_pkg::*;

    byte_t mem [HIST_DEPTH];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/yaz0_lz_decompressor_core.sv */
`default_nettype none

// Yaz0 stream decompressor. Compressed bytes enter one per beat on in_ch, header
// included; decompressed bytes leave on out_ch in beats of up to eight, earliest byte
// in the low lane, and every input byte ends with exactly one beat marked end_of_run
// that carries the sticky done and error status. A back-reference copy moves one byte
// a cycle, unless a full beat is waiting on a stalled output, through the single read
// port and single write port of the 4096-byte history memory; a maximal copy is 273
// bytes. in_ch is not ready while an item is in progress. After done or an error every
// further byte returns one empty status beat; after an error the bytes already sent
// are to be discarded.
module yaz0_lz_decompressor_core (
    input  wire clk,
    input  wire rst_n,
    yaz0_in_if.sink   in_ch,
    yaz0_out_if.source out_ch
);
    import yaz0_pkg::*;

    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    err_t        err_reg, err_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] produced_reg, produced_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  bits_reg, bits_next;
    logic [7:0]  ref1_reg, ref1_next;
    logic [12:0] dist_reg, dist_next;
    logic [8:0]  copy_left_reg, copy_left_next;
    logic        last_in_reg, last_in_next;
    byte_t       last_byte_reg, last_byte_next;
    logic [PACK_W-1:0] pack_reg, pack_next;
    logic [CNT_W-1:0]  pack_n_reg, pack_n_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_bytes_reg, out_bytes_next;
    logic [3:0]  out_count_reg, out_count_next;
    logic        out_end_reg, out_end_next;
    logic        out_done_reg, out_done_next;
    err_t        out_err_reg, out_err_next;

    logic        mem_we;
    hist_addr_t  mem_waddr;
    byte_t       mem_wdata;
    hist_addr_t  mem_raddr;
    byte_t       mem_rdata;

    byte_t       b;
    byte_t       copy_byte;
    logic        out_free;
    logic        pack_full;
    logic        advance;
    logic        cp_go;
    logic [8:0]  cp_len;
    logic [12:0] cp_dist;
    item_state_t idn;

    function automatic item_state_t item_done(input logic [7:0] flag,
                                              input logic [3:0] bits_left,
                                              input logic [31:0] produced,
                                              input logic [31:0] size);
        item_state_t r;
        r.flag      = {flag[6:0], 1'b0};
        r.bits_left = (bits_left != 4'd0) ? bits_left - 4'd1 : 4'd0;
        if (produced >= size)
            r.phase = PH_DONE;
        else if (r.bits_left == 4'd0)
            r.phase = PH_FLAG;
        else
            r.phase = r.flag[7] ? PH_LIT : PH_REF1;
        return r;
    endfunction

    yaz0_hist_ram u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign b         = in_ch.in_byte;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign pack_full = (pack_n_reg == CNT_W'(LANES));
    // distance one reads the byte written in the same cycle, so take it from the register
    assign copy_byte = (dist_reg == 13'd1) ? last_byte_reg : mem_rdata;

    assign in_ch.ready       = (seq_reg == SQ_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_bytes  = out_bytes_reg;
    assign out_ch.out_count  = out_count_reg;
    assign out_ch.end_of_run = out_end_reg;
    assign out_ch.done_res   = out_done_reg;
    assign out_ch.error_code = out_err_reg;

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        err_next       = err_reg;
        hdr_idx_next   = hdr_idx_reg;
        size_next      = size_reg;
        produced_next  = produced_reg;
        flag_next      = flag_reg;
        bits_next      = bits_reg;
        ref1_next      = ref1_reg;
        dist_next      = dist_reg;
        copy_left_next = copy_left_reg;
        last_in_next   = last_in_reg;
        last_byte_next = last_byte_reg;
        pack_next      = pack_reg;
        pack_n_next    = pack_n_reg;

        out_valid_next = out_valid_reg && !out_ch.ready;
        out_bytes_next = out_bytes_reg;
        out_count_next = out_count_reg;
        out_end_next   = out_end_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;

        mem_we    = 1'b0;
        mem_waddr = produced_reg[HIST_AW-1:0];
        mem_wdata = b;
        mem_raddr = produced_reg[HIST_AW-1:0] - dist_reg[HIST_AW-1:0];

        advance = 1'b0;
        cp_go   = 1'b0;
        cp_len  = 9'd0;
        cp_dist = dist_reg;
        idn     = item_done(flag_reg, bits_reg, produced_reg, size_reg);

        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (in_ch.valid)
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (hdr_idx_reg < 5'(MAGIC_LEN) &&
                                b != MAGIC[hdr_idx_reg[1:0]])
                            begin
                                phase_next = PH_ERROR;
                                err_next   = ERR_MAGIC;
                            end
                            else
                            begin
                                if (hdr_idx_reg >= 5'(SIZE_FIRST) &&
                                    hdr_idx_reg < 5'(SIZE_END))
                                begin
                                    size_next = {size_reg[23:0], b};
                                end
                                hdr_idx_next = hdr_idx_reg + 5'd1;
                                if (hdr_idx_reg == 5'(HDR_LEN - 1))
                                begin
                                    phase_next = (size_next == 32'd0) ? PH_DONE : PH_FLAG;
                                end
                            end
                        end
                        PH_FLAG:
                        begin
                            flag_next  = b;
                            bits_next  = 4'd8;
                            phase_next = b[7] ? PH_LIT : PH_REF1;
                        end
                        PH_LIT:
                        begin
                            mem_we         = 1'b1;
                            produced_next  = produced_reg + 32'd1;
                            last_byte_next = b;
                            pack_next      = PACK_W'(b);
                            pack_n_next    = CNT_W'(1);
                            idn = item_done(flag_reg, bits_reg, produced_next, size_reg);
                            flag_next  = idn.flag;
                            bits_next  = idn.bits_left;
                            phase_next = idn.phase;
                        end
                        PH_REF1:
                        begin
                            ref1_next  = b;
                            phase_next = PH_REF2;
                        end
                        PH_REF2:
                        begin
                            cp_dist   = 13'({ref1_reg[3:0], b}) + 13'd1;
                            dist_next = cp_dist;
                            if (ref1_reg[7:4] == 4'd0)
                            begin
                                phase_next = PH_REF3;
                            end
                            else
                            begin
                                cp_go  = 1'b1;
                                cp_len = 9'(ref1_reg[7:4]) + SHORT_LEN_BASE;
                            end
                        end
                        PH_REF3:
                        begin
                            cp_go  = 1'b1;
                            cp_len = 9'(b) + LONG_LEN_BASE;
                        end
                        PH_DONE, PH_ERROR:
                        begin
                        end
                    endcase

                    if (cp_go)
                    begin
                        if (32'(cp_dist) > produced_reg)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_DIST;
                        end
                        else if (32'(cp_len) > size_reg - produced_reg)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_OVERRUN;
                        end
                        else
                        begin
                            seq_next       = SQ_PRIME;
                            copy_left_next = cp_len;
                            last_in_next   = in_ch.in_last;
                        end
                    end

                    if (seq_next != SQ_PRIME)
                    begin
                        if (in_ch.in_last && phase_next != PH_DONE &&
                            phase_next != PH_ERROR)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_TRUNC;
                        end
                        seq_next = SQ_FINAL;
                    end
                end
            end
            SQ_PRIME:
            begin
                seq_next = SQ_COPY;
            end
            SQ_COPY:
            begin
                advance = !pack_full || out_free;
                // prefetch the next source byte once this one is taken
                mem_raddr = produced_reg[HIST_AW-1:0] - dist_reg[HIST_AW-1:0]
                            + HIST_AW'(advance);
                if (advance)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = copy_byte;
                    produced_next  = produced_reg + 32'd1;
                    last_byte_next = copy_byte;
                    copy_left_next = copy_left_reg - 9'd1;
                    if (pack_full)
                    begin
                        out_valid_next = 1'b1;
                        out_bytes_next = 64'(pack_reg);
                        out_count_next = 4'(pack_n_reg);
                        out_end_next   = 1'b0;
                        out_done_next  = 1'b0;
                        out_err_next   = ERR_NONE;
                        pack_next      = PACK_W'(copy_byte);
                        pack_n_next    = CNT_W'(1);
                    end
                    else
                    begin
                        pack_next   = pack_reg | (PACK_W'(copy_byte) << {pack_n_reg, 3'b000});
                        pack_n_next = pack_n_reg + CNT_W'(1);
                    end
                    if (copy_left_reg == 9'd1)
                    begin
                        idn = item_done(flag_reg, bits_reg, produced_next, size_reg);
                        flag_next  = idn.flag;
                        bits_next  = idn.bits_left;
                        phase_next = idn.phase;
                        if (last_in_reg && idn.phase != PH_DONE)
                        begin
                            phase_next = PH_ERROR;
                            err_next   = ERR_TRUNC;
                        end
                        seq_next = SQ_FINAL;
                    end
                end
            end
            SQ_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_bytes_next = 64'(pack_reg);
                    out_count_next = 4'(pack_n_reg);
                    out_end_next   = 1'b1;
                    out_done_next  = (phase_reg == PH_DONE);
                    out_err_next   = err_reg;
                    pack_next      = '0;
                    pack_n_next    = '0;
                    seq_next       = SQ_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SQ_IDLE;
            phase_reg     <= PH_HEADER;
            err_reg       <= ERR_NONE;
            hdr_idx_reg   <= '0;
            size_reg      <= '0;
            produced_reg  <= '0;
            flag_reg      <= '0;
            bits_reg      <= '0;
            ref1_reg      <= '0;
            dist_reg      <= '0;
            copy_left_reg <= '0;
            last_in_reg   <= 1'b0;
            pack_reg      <= '0;
            pack_n_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            hdr_idx_reg   <= hdr_idx_next;
            size_reg      <= size_next;
            produced_reg  <= produced_next;
            flag_reg      <= flag_next;
            bits_reg      <= bits_next;
            ref1_reg      <= ref1_next;
            dist_reg      <= dist_next;
            copy_left_reg <= copy_left_next;
            last_in_reg   <= last_in_next;
            pack_reg      <= pack_next;
            pack_n_reg    <= pack_n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_byte_reg <= last_byte_next;
        out_bytes_reg <= out_bytes_next;
        out_count_reg <= out_count_next;
        out_end_reg   <= out_end_next;
        out_done_reg  <= out_done_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire

/* dv/yaz0_lz_decompressor_core_tb.sv */
`timescale 1ns / 100ps

module yaz0_lz_decompressor_core_tb;
    import yaz0_pkg::*;

    localparam int MAX_BEATS = 35;
    localparam int MAX_GAP   = 13;

    typedef enum {
        RUN_BAD_MAGIC,
        RUN_ZERO_SIZE,
        RUN_FAR_DIST,
        RUN_OVERRUN,
        RUN_TRUNCATED,
        RUN_CLEAN
    } run_kind_t;

    typedef struct {
        byte_t value;
        logic  last;
    } stream_item_t;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        eor;
        logic        done;
        err_t        err;
    } out_beat_t;

    logic clk;
    logic rst_n;

    yaz0_in_if  in_ch ();
    yaz0_out_if out_ch ();

    yaz0_lz_decompressor_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stream_item_t stream_q[$];
    out_beat_t    owed_beats[$];

    int  fails;
    int  cycles;
    int  cycle_limit;
    logic in_took;
    logic out_took;
    int  in_wait;
    int  out_stall;
    bit  in_calm;
    bit  out_calm;

    // decoder state mirrored by the predictor
    byte_t       hist [HIST_DEPTH];
    int          hdr_idx;
    logic [31:0] decl_size;
    logic [31:0] produced;
    logic [7:0]  flag_sr;
    int          bits_left;
    phase_t      ph;
    byte_t       ref_b1;
    logic [31:0] ref_reach;
    err_t        err_st;
    logic [63:0] pk_data;
    int          pk_n;
    int          beats_now;

    // stream builder state
    byte_t       grp_q[$];
    logic [7:0]  grp_flag;
    int          grp_n;
    logic [31:0] gen_made;

    task automatic flush_beat(bit fin);
        out_beat_t bt;
        if (beats_now < MAX_BEATS) begin
            bt.data  = pk_data;
            bt.count = 4'(pk_n);
            bt.eor   = fin;
            bt.done  = fin && ph == PH_DONE;
            bt.err   = fin ? err_st : ERR_NONE;
            owed_beats.push_back(bt);
        end
        beats_now++;
        pk_data = '0;
        pk_n    = 0;
    endtask

    task automatic emit_out(byte_t v);
        hist[produced[HIST_AW-1:0]] = v;
        produced++;
        if (pk_n >= LANES)
            flush_beat(1'b0);
        pk_data[8*pk_n +: 8] = v;
        pk_n++;
    endtask

    task automatic raise_error(err_t code);
        err_st = code;
        ph     = PH_ERROR;
    endtask

    task automatic choose_next();
        ph = flag_sr[7] ? PH_LIT : PH_REF1;
    endtask

    task automatic close_item();
        flag_sr = {flag_sr[6:0], 1'b0};
        if (bits_left > 0)
            bits_left--;
        if (produced >= decl_size)
            ph = PH_DONE;
        else if (bits_left == 0)
            ph = PH_FLAG;
        else
            choose_next();
    endtask

    task automatic copy_back(int unsigned len);
        logic [31:0] src;
        if (ref_reach > produced) begin
            raise_error(ERR_DIST);
            return;
        end
        // distance is checked first, so a far copy never reports overrun
        if (len > decl_size - produced) begin
            raise_error(ERR_OVERRUN);
            return;
        end
        for (int i = 0; i < len; i++) begin
            src = produced - ref_reach;
            emit_out(hist[src[HIST_AW-1:0]]);
        end
        close_item();
    endtask

    task automatic decode_byte(byte_t v, logic last);
        pk_data   = '0;
        pk_n      = 0;
        beats_now = 0;
        if (ph == PH_DONE || ph == PH_ERROR) begin
            flush_beat(1'b1);
            return;
        end
        case (ph)
            PH_HEADER: begin
                if (hdr_idx < MAGIC_LEN && v != MAGIC[hdr_idx]) begin
                    raise_error(ERR_MAGIC);
                end else begin
                    if (hdr_idx >= SIZE_FIRST && hdr_idx < SIZE_END)
                        decl_size = {decl_size[23:0], v};
                    hdr_idx++;
                    if (hdr_idx >= HDR_LEN)
                        ph = (decl_size == 0) ? PH_DONE : PH_FLAG;
                end
            end
            PH_FLAG: begin
                flag_sr   = v;
                bits_left = 8;
                choose_next();
            end
            PH_LIT: begin
                emit_out(v);
                close_item();
            end
            PH_REF1: begin
                ref_b1 = v;
                ph     = PH_REF2;
            end
            PH_REF2: begin
                ref_reach = {ref_b1[3:0], v} + 1;
                if (ref_b1[7:4] == 0)
                    ph = PH_REF3;
                else
                    copy_back(ref_b1[7:4] + 2);
            end
            PH_REF3: begin
                copy_back(v + LONG_LEN_BASE);
            end
            default: begin
            end
        endcase
        if (last && ph != PH_DONE && ph != PH_ERROR)
            raise_error(ERR_TRUNC);
        flush_beat(1'b1);
    endtask

    task automatic push_in(byte_t v, logic last);
        stream_item_t it;
        it.value = v;
        it.last  = last;
        stream_q.push_back(it);
    endtask

    task automatic close_group();
        if (grp_n == 0)
            return;
        for (int i = grp_n; i < 8; i++)
            grp_flag[7-i] = 1'($urandom_range(0, 1));
        push_in(grp_flag, 1'b0);
        foreach (grp_q[i])
            push_in(grp_q[i], 1'b0);
        grp_q.delete();
        grp_n    = 0;
        grp_flag = '0;
    endtask

    task automatic count_op(bit is_lit);
        grp_flag[7-grp_n] = is_lit;
        grp_n++;
        if (grp_n == 8)
            close_group();
    endtask

    task automatic add_lit(byte_t v);
        grp_q.push_back(v);
        gen_made++;
        count_op(1'b1);
    endtask

    task automatic add_ref(int unsigned len, int unsigned reach);
        logic [11:0] d;
        logic [7:0]  n;
        d = 12'(reach - 1);
        if (len <= 17) begin
            n = 8'(len - 2);
            grp_q.push_back({n[3:0], d[11:8]});
            grp_q.push_back(d[7:0]);
        end else begin
            n = 8'(len - 18);
            grp_q.push_back({4'h0, d[11:8]});
            grp_q.push_back(d[7:0]);
            grp_q.push_back(n);
        end
        gen_made += len;
        count_op(1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // input acceptance feeds the predictor
    always @(posedge clk)
    begin
        in_took <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            decode_byte(in_ch.in_byte, in_ch.in_last);
            void'(stream_q.pop_front());
        end
    end

    always @(negedge clk)
    begin
        int gap;
        if (rst_n) begin
            if (in_ch.valid && !in_took) begin
                // beat still waiting for ready
            end else if (in_wait > 0) begin
                in_ch.valid <= 1'b0;
                in_wait = in_wait - 1;
            end else if (stream_q.size() > 0) begin
                if ($urandom_range(0, 23) == 0)
                    in_calm = !in_calm;
                gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= stream_q[0].value;
                in_ch.in_last <= stream_q[0].last;
                in_wait = gap;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        out_took <= rst_n && out_ch.valid && out_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (owed_beats.size() == 0) begin
                $error("unexpected beat: out_bytes %h, out_count %0d",
                       out_ch.out_bytes, out_ch.out_count);
                fails++;
            end else begin
                want = owed_beats.pop_front();
                if (out_ch.out_bytes !== want.data) begin
                    $error("out_bytes: expected %h, actual %h", want.data, out_ch.out_bytes);
                    fails++;
                end
                if (out_ch.out_count !== want.count) begin
                    $error("out_count: expected %0d, actual %0d", want.count, out_ch.out_count);
                    fails++;
                end
                if (out_ch.end_of_run !== want.eor) begin
                    $error("end_of_run: expected %0d, actual %0d", want.eor,
                           out_ch.end_of_run);
                    fails++;
                end
                if (out_ch.done_res !== want.done) begin
                    $error("done_res: expected %0d, actual %0d", want.done, out_ch.done_res);
                    fails++;
                end
                if (out_ch.error_code !== want.err) begin
                    $error("error_code: expected %0d, actual %0d", want.err,
                           out_ch.error_code);
                    fails++;
                end
            end
        end
    end

    // stall drawn after every accepted beat
    always @(negedge clk)
    begin
        int st;
        if (rst_n) begin
            if (out_took) begin
                if ($urandom_range(0, 23) == 0)
                    out_calm = !out_calm;
                st = out_calm ? 0 : $urandom_range(0, MAX_GAP);
                out_stall = st;
                out_ch.ready <= (st == 0);
            end else if (out_stall > 0) begin
                out_stall = out_stall - 1;
                out_ch.ready <= (out_stall == 0);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        run_kind_t   kind;
        int          bad_at;
        int          op_cnt;
        int          inject_at;
        int          cut;
        int          pick;
        byte_t       v;
        logic [31:0] gen_size;
        int unsigned rem;
        int unsigned max_reach;
        int unsigned top;
        int unsigned len;
        int unsigned reach;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        fails         = 0;
        cycles        = 0;
        cycle_limit   = 1000000;
        in_took       = 1'b0;
        out_took      = 1'b0;
        in_wait       = 0;
        out_stall     = 0;
        in_calm       = 1'b0;
        out_calm      = 1'b0;

        hdr_idx   = 0;
        decl_size = '0;
        produced  = '0;
        flag_sr   = '0;
        bits_left = 0;
        ph        = PH_HEADER;
        ref_b1    = '0;
        ref_reach = '0;
        err_st    = ERR_NONE;

        grp_flag = '0;
        grp_n    = 0;
        gen_made = '0;

        // one stream per reset, so the terminal case is picked per seed
        case ($urandom_range(0, 11))
            0:       kind = RUN_BAD_MAGIC;
            1:       kind = RUN_ZERO_SIZE;
            2, 3:    kind = RUN_FAR_DIST;
            4, 5:    kind = RUN_OVERRUN;
            6, 7:    kind = RUN_TRUNCATED;
            default: kind = RUN_CLEAN;
        endcase

        bad_at = (kind == RUN_BAD_MAGIC) ? $urandom_range(0, MAGIC_LEN - 1) : MAGIC_LEN;
        for (int i = 0; i < MAGIC_LEN; i++) begin
            v = MAGIC[i];
            if (i == bad_at) begin
                v = v ^ 8'($urandom_range(1, 255));
                push_in(v, 1'($urandom_range(0, 1)));
                break;
            end
            push_in(v, 1'b0);
        end

        if (kind != RUN_BAD_MAGIC) begin
            gen_size = (kind == RUN_ZERO_SIZE) ? 32'd0 : 32'($urandom_range(4200, 5200));
            push_in(gen_size[31:24], 1'b0);
            push_in(gen_size[23:16], 1'b0);
            push_in(gen_size[15:8], 1'b0);
            push_in(gen_size[7:0], 1'b0);
            repeat (HDR_LEN - SIZE_END)
                push_in(8'($urandom_range(0, 255)), 1'b0);
        end

        if (kind != RUN_BAD_MAGIC && kind != RUN_ZERO_SIZE) begin
            // literal extremes, shortest and longest of both reference forms
            add_lit(8'h00);
            add_lit(8'hFF);
            add_ref(3, 1);
            add_ref(17, 2);
            add_ref(18, 1);
            add_ref(273, 2);
            add_lit(8'hA5);
            add_ref(9, 5);
            op_cnt    = 8;
            inject_at = $urandom_range(8, 40);
            while (gen_made < gen_size) begin
                rem       = gen_size - gen_made;
                max_reach = (gen_made < HIST_DEPTH) ? gen_made : HIST_DEPTH;
                // stays below the full window so an unreachable distance exists
                if (kind == RUN_FAR_DIST && (op_cnt >= inject_at || gen_made >= 3823)) begin
                    add_ref($urandom_range(3, 273), $urandom_range(gen_made + 1, HIST_DEPTH));
                    break;
                end
                if (kind == RUN_OVERRUN && rem < 273) begin
                    add_ref($urandom_range((rem + 1 < 3) ? 3 : rem + 1, 273),
                            $urandom_range(1, max_reach));
                    break;
                end
                if ($urandom_range(0, 9) < 4 || rem < 3) begin
                    add_lit(8'($urandom_range(0, 255)));
                end else begin
                    pick  = $urandom_range(0, 7);
                    reach = (pick == 0) ? 1 :
                            (pick == 1) ? max_reach : $urandom_range(1, max_reach);
                    if (rem >= 18 && $urandom_range(0, 1)) begin
                        top = (rem < 273) ? rem : 273;
                        // keep some bytes owed so the overrun copy can still happen
                        if (kind == RUN_OVERRUN && top == rem)
                            top--;
                        pick = $urandom_range(0, 5);
                        len  = (pick == 0) ? 18 :
                               (pick == 1) ? top : $urandom_range(18, top);
                    end else begin
                        len = $urandom_range(3, (rem < 17) ? rem : 17);
                    end
                    add_ref(len, reach);
                end
                op_cnt++;
            end
            close_group();
        end

        if (kind == RUN_TRUNCATED) begin
            cut = $urandom_range(0, stream_q.size() - 2);
            while (stream_q.size() > cut + 1)
                void'(stream_q.pop_back());
            stream_q[stream_q.size()-1].last = 1'b1;
        end else begin
            stream_q[stream_q.size()-1].last = 1'($urandom_range(0, 1));
        end

        // bytes after done or error only return status beats
        repeat ($urandom_range(8, 20))
            push_in(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        cycle_limit = stream_q.size() * 4000 + 20000;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stream_q.size() != 0 || owed_beats.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* files.f */
src/yaz0_pkg.sv
src/yaz0_in_if.sv
src/yaz0_out_if.sv
src/yaz0_hist_ram.sv
src/yaz0_lz_decompressor_core.sv
dv/yaz0_lz_decompressor_core_tb.sv
